// File: rtl/mtf_pkg.sv
// ----------------------------------------------------------------------------
// mtf_pkg
// Shared constants, types and sequencer states of the minimum degree-sum
// triangle finder.
// ----------------------------------------------------------------------------
package mtf_pkg;

  // Graph size and counter widths.
  localparam int MAX_NODES   = 64;
  localparam int DEGREE_BITS = 12;
  localparam int NODE_W      = 6;
  localparam int ADDR_W      = $clog2(MAX_NODES);
  localparam int CNT_W       = $clog2(MAX_NODES + 1);

  // Result field and triangle sum arithmetic.
  localparam int OUT_W      = 14;
  localparam int SUM_W      = DEGREE_BITS + 2;
  localparam int CALC_W     = (SUM_W > OUT_W) ? SUM_W : OUT_W;
  localparam int TRI_OFFSET = 6;

  typedef logic [NODE_W-1:0]      node_t;
  typedef logic [ADDR_W-1:0]      addr_t;
  typedef logic [CNT_W-1:0]       cnt_t;
  typedef logic [MAX_NODES-1:0]   row_t;
  typedef logic [DEGREE_BITS-1:0] deg_t;
  typedef logic [OUT_W-1:0]       out_t;
  typedef logic [CALC_W-1:0]      calc_t;

  localparam deg_t DEG_MAX = '1;
  localparam out_t OUT_MAX = '1;

  // One node entry: its adjacency row and its degree counter.
  typedef struct packed {
    row_t row;
    deg_t deg;
  } entry_t;

  // Commands from the sequencer to the shared sum and compare unit.
  typedef struct packed {
    logic take_i;
    logic take_j;
    logic take_k;
    logic clear;
  } acc_ctl_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_INS_RD_A,
    ST_INS_WR_A,
    ST_INS_RD_B,
    ST_INS_WR_B,
    ST_SRCH_I,
    ST_SRCH_ROW,
    ST_SRCH_J,
    ST_SRCH_JROW,
    ST_SRCH_K,
    ST_SRCH_KSUM,
    ST_SRCH_DONE
  } state_t;

endpackage

// File: rtl/mtf_if.sv
// ----------------------------------------------------------------------------
// mtf_if
// Valid/ready channels of the triangle finder: edge items in, results out.
// ----------------------------------------------------------------------------
interface mtf_edge_if;
  import mtf_pkg::*;

  logic  valid;
  logic  ready;
  node_t node_a;
  node_t node_b;
  logic  last_edge;

  modport source (output valid, node_a, node_b, last_edge, input ready);
  modport sink (input valid, node_a, node_b, last_edge, output ready);
endinterface

interface mtf_result_if;
  import mtf_pkg::*;

  logic valid;
  logic ready;
  logic found;
  out_t min_outside_degree;

  modport source (output valid, found, min_outside_degree, input ready);
  modport sink (input valid, found, min_outside_degree, output ready);
endinterface

// File: rtl/min_degree_triangle_finder.sv
// ----------------------------------------------------------------------------
// min_degree_triangle_finder
// Top level: builds an undirected graph from a stream of edges and reports
// the smallest degree sum minus six over all of its triangles.
// ----------------------------------------------------------------------------
// Each edge item is accepted in ST_IDLE; then both endpoint entries are
// read-modify-written in turn through the read and write ports of the node
// memory, and no new item is accepted until the insert is done. The item
// marked last adds the triangle walk, which reads the memory for each first
// node i, for each second node j > i, and for each third node k > j of each
// edge (i, j), with one more step per triangle found. The result sits in an
// output register, and the graph is cleared in the cycle the result is
// loaded, so the next graph can start at once.
// ----------------------------------------------------------------------------
module min_degree_triangle_finder (
  input logic          clk,
  input logic          rst,
  mtf_edge_if.sink     edges,
  mtf_result_if.source result
);
  import mtf_pkg::*;

  addr_t    rd_addr;
  logic     wr_en;
  addr_t    wr_addr;
  entry_t   wr_entry;
  entry_t   rd_entry;
  logic     clr;
  acc_ctl_t acc_ctl;
  logic     acc_found;
  out_t     acc_best;

  // Node memory.
  mtf_store u_store (
    .clk      (clk),
    .rst      (rst),
    .rd_addr  (rd_addr),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_entry (wr_entry),
    .clr      (clr),
    .rd_entry (rd_entry)
  );

  // Shared sum and compare unit.
  mtf_acc u_acc (
    .clk   (clk),
    .rst   (rst),
    .ctl   (acc_ctl),
    .deg   (rd_entry.deg),
    .found (acc_found),
    .best  (acc_best)
  );

  // Sequencer.
  mtf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .edges     (edges),
    .result    (result),
    .rd_entry  (rd_entry),
    .acc_found (acc_found),
    .acc_best  (acc_best),
    .rd_addr   (rd_addr),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_entry  (wr_entry),
    .clr       (clr),
    .acc_ctl   (acc_ctl)
  );

endmodule

// File: rtl/mtf_store.sv
// ----------------------------------------------------------------------------
// mtf_store
// Node memory holding adjacency rows and degree counters, one read and one
// write port, with a valid bit per node so the whole graph clears at once.
// ----------------------------------------------------------------------------
module mtf_store (
  input  logic           clk,
  input  logic           rst,
  input  mtf_pkg::addr_t rd_addr,
  input  logic           wr_en,
  input  mtf_pkg::addr_t wr_addr,
  input  mtf_pkg::entry_t wr_entry,
  input  logic           clr,
  output mtf_pkg::entry_t rd_entry
);
  import mtf_pkg::*;

  entry_t               mem [MAX_NODES];
  logic [MAX_NODES-1:0] valid;
  entry_t               rd_data;
  logic                 rd_valid;

  // Memory array: write and registered read.
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_entry;
    end
    rd_data <= mem[rd_addr];
  end

  // Per-node valid bits; a node never written reads as an empty entry.
  always_ff @(posedge clk) begin
    if (rst || clr) begin
      valid    <= '0;
      rd_valid <= 1'b0;
    end else begin
      if (wr_en) begin
        valid[wr_addr] <= 1'b1;
      end
      rd_valid <= valid[rd_addr];
    end
  end

  assign rd_entry = rd_valid ? rd_data : '0;

endmodule

// File: rtl/mtf_acc.sv
// ----------------------------------------------------------------------------
// mtf_acc
// Shared sum and compare unit: forms the degree sum of each triangle, takes
// off the offset, saturates it and keeps the running minimum.
// ----------------------------------------------------------------------------
module mtf_acc (
  input  logic              clk,
  input  logic              rst,
  input  mtf_pkg::acc_ctl_t ctl,
  input  mtf_pkg::deg_t     deg,
  output logic              found,
  output mtf_pkg::out_t     best
);
  import mtf_pkg::*;

  deg_t                 deg_i;
  logic [DEGREE_BITS:0] pair;
  calc_t                sum;
  calc_t                adj;
  out_t                 tri_val;

  // Triangle value: sum of three degrees minus the offset, clamped to range.
  always_comb begin
    sum = calc_t'(pair) + calc_t'(deg);
    adj = (sum >= calc_t'(TRI_OFFSET)) ? sum - calc_t'(TRI_OFFSET) : '0;
    tri_val = (adj > calc_t'(OUT_MAX)) ? OUT_MAX : adj[OUT_W-1:0];
  end

  // Partial sums for the current first and second node.
  always_ff @(posedge clk) begin
    if (ctl.take_i) begin
      deg_i <= deg;
    end
    if (ctl.take_j) begin
      pair <= {1'b0, deg_i} + {1'b0, deg};
    end
  end

  // Running minimum and found flag.
  always_ff @(posedge clk) begin
    if (rst || ctl.clear) begin
      found <= 1'b0;
      best  <= OUT_MAX;
    end else if (ctl.take_k) begin
      found <= 1'b1;
      if (tri_val < best) begin
        best <= tri_val;
      end
    end
  end

  a_best_idle: assert property (@(posedge clk) disable iff (rst)
    !found |-> best == OUT_MAX)
    else $error("minimum moved without any triangle found");

endmodule

// File: rtl/mtf_ctrl.sv
// ----------------------------------------------------------------------------
// mtf_ctrl
// Sequencer: inserts each edge by read-modify-write of both endpoint entries,
// then on the last edge walks all node triples and hands out the result.
// ----------------------------------------------------------------------------
module mtf_ctrl (
  input  logic              clk,
  input  logic              rst,
  mtf_edge_if.sink          edges,
  mtf_result_if.source      result,
  input  mtf_pkg::entry_t   rd_entry,
  input  logic              acc_found,
  input  mtf_pkg::out_t     acc_best,
  output mtf_pkg::addr_t    rd_addr,
  output logic              wr_en,
  output mtf_pkg::addr_t    wr_addr,
  output mtf_pkg::entry_t   wr_entry,
  output logic              clr,
  output mtf_pkg::acc_ctl_t acc_ctl
);
  import mtf_pkg::*;

  state_t state;
  state_t state_next;
  node_t  a_r;
  node_t  b_r;
  logic   last_r;
  addr_t  i_cnt;
  cnt_t   j_cnt;
  cnt_t   k_cnt;
  row_t   row_i;
  row_t   cand;
  logic   out_valid;
  logic   out_found;
  out_t   out_val;
  logic   accept;
  logic   in_range;
  logic   load_out;
  logic   j_end;
  logic   k_end;
  deg_t   deg_inc;

  assign accept   = edges.valid && edges.ready;
  assign in_range = (int'(edges.node_a) < MAX_NODES) && (int'(edges.node_b) < MAX_NODES);
  assign j_end    = (j_cnt == cnt_t'(MAX_NODES));
  assign k_end    = (k_cnt == cnt_t'(MAX_NODES));
  assign deg_inc  = (rd_entry.deg == DEG_MAX) ? rd_entry.deg : rd_entry.deg + 1'b1;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_range) state_next = ST_INS_RD_A;
          else if (edges.last_edge) state_next = ST_SRCH_I;
        end
      end
      ST_INS_RD_A: state_next = ST_INS_WR_A;
      ST_INS_WR_A: state_next = ST_INS_RD_B;
      ST_INS_RD_B: state_next = ST_INS_WR_B;
      ST_INS_WR_B: state_next = last_r ? ST_SRCH_I : ST_IDLE;
      ST_SRCH_I:   state_next = ST_SRCH_ROW;
      ST_SRCH_ROW: state_next = ST_SRCH_J;
      ST_SRCH_J: begin
        if (j_end) begin
          state_next = (i_cnt == addr_t'(MAX_NODES - 1)) ? ST_SRCH_DONE : ST_SRCH_I;
        end else if (row_i[j_cnt[ADDR_W-1:0]]) begin
          state_next = ST_SRCH_JROW;
        end
      end
      ST_SRCH_JROW: state_next = ST_SRCH_K;
      ST_SRCH_K: begin
        if (k_end) state_next = ST_SRCH_J;
        else if (cand[k_cnt[ADDR_W-1:0]]) state_next = ST_SRCH_KSUM;
      end
      ST_SRCH_KSUM: state_next = ST_SRCH_K;
      ST_SRCH_DONE: begin
        if (!out_valid || result.ready) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory port, shared unit commands and handshake.
  always_comb begin
    edges.ready = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = a_r[ADDR_W-1:0];
    wr_entry    = '0;
    clr         = 1'b0;
    load_out    = 1'b0;
    acc_ctl     = '0;
    unique case (state)
      ST_IDLE:     edges.ready = 1'b1;
      ST_INS_RD_A: rd_addr = a_r[ADDR_W-1:0];
      ST_INS_WR_A: begin
        wr_en        = 1'b1;
        wr_addr      = a_r[ADDR_W-1:0];
        wr_entry.row = rd_entry.row | (row_t'(1) << b_r);
        wr_entry.deg = deg_inc;
      end
      ST_INS_RD_B: rd_addr = b_r[ADDR_W-1:0];
      ST_INS_WR_B: begin
        wr_en        = 1'b1;
        wr_addr      = b_r[ADDR_W-1:0];
        wr_entry.row = rd_entry.row | (row_t'(1) << a_r);
        wr_entry.deg = deg_inc;
      end
      ST_SRCH_I:    rd_addr = i_cnt;
      ST_SRCH_ROW:  acc_ctl.take_i = 1'b1;
      ST_SRCH_J:    rd_addr = j_cnt[ADDR_W-1:0];
      ST_SRCH_JROW: acc_ctl.take_j = 1'b1;
      ST_SRCH_K:    rd_addr = k_cnt[ADDR_W-1:0];
      ST_SRCH_KSUM: acc_ctl.take_k = 1'b1;
      ST_SRCH_DONE: begin
        if (!out_valid || result.ready) begin
          load_out      = 1'b1;
          clr           = 1'b1;
          acc_ctl.clear = 1'b1;
        end
      end
      default: ;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Edge latch and walk counters.
  always_ff @(posedge clk) begin
    if (accept) begin
      a_r    <= edges.node_a;
      b_r    <= edges.node_b;
      last_r <= edges.last_edge;
      i_cnt  <= '0;
    end
    unique case (state)
      ST_INS_WR_B: i_cnt <= '0;
      ST_SRCH_ROW: begin
        row_i <= rd_entry.row;
        j_cnt <= cnt_t'(i_cnt) + 1'b1;
      end
      ST_SRCH_J: begin
        if (j_end) begin
          i_cnt <= i_cnt + 1'b1;
        end else if (!row_i[j_cnt[ADDR_W-1:0]]) begin
          j_cnt <= j_cnt + 1'b1;
        end
      end
      ST_SRCH_JROW: begin
        cand  <= row_i & rd_entry.row;
        k_cnt <= j_cnt + 1'b1;
      end
      ST_SRCH_K: begin
        if (k_end) begin
          j_cnt <= j_cnt + 1'b1;
        end else if (!cand[k_cnt[ADDR_W-1:0]]) begin
          k_cnt <= k_cnt + 1'b1;
        end
      end
      ST_SRCH_KSUM: k_cnt <= k_cnt + 1'b1;
      default: ;
    endcase
  end

  // Result register: parts the walk from the output side.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_found <= acc_found;
      out_val   <= acc_found ? acc_best : '0;
    end
  end

  assign result.valid              = out_valid;
  assign result.found              = out_found;
  assign result.min_outside_degree = out_val;

  a_j_after_i: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_J && !j_end) |-> j_cnt > cnt_t'(i_cnt))
    else $error("second node not above first node");

  a_k_after_j: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SRCH_K && !k_end) |-> k_cnt > j_cnt)
    else $error("third node not above second node");

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_SRCH_DONE))
    else $error("result raised outside the end of a walk");

  a_busy_not_ready: assert property (@(posedge clk) disable iff (rst)
    (accept && in_range) |=> !edges.ready)
    else $error("new edge offered while an insert is in progress");

endmodule

// File: tb/tb_min_degree_triangle_finder.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_min_degree_triangle_finder
// Streams edge lists into the triangle finder and checks every reported
// result against a cycle-free model of the graph kept in the testbench.
// Directed graphs cover the node extremes, self-loops, duplicate edges,
// and graphs with and without triangles. Random graphs
// follow, built mostly from small node pools so that triangles are common,
// with stray edges and self-loops mixed in. Both channels stall at random.
// ----------------------------------------------------------------------------
module tb_min_degree_triangle_finder;
  import mtf_pkg::*;

  // Expected content of one result transfer.
  typedef struct {
    logic found;
    out_t min_deg;
  } tri_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;

  mtf_edge_if   edge_ch ();
  mtf_result_if result_ch ();

  min_degree_triangle_finder DUT (
    .clk    (clk),
    .rst    (rst),
    .edges  (edge_ch),
    .result (result_ch)
  );

  // Graph model: adjacency rows and saturating degree counters.
  row_t adj_rows [MAX_NODES];
  deg_t node_deg [MAX_NODES];

  tri_result_t pending_triangle_results[$];
  int          error_count = 0;
  int          send_idle_pct = 0;
  int          take_idle_pct = 0;

  always #5 clk = ~clk;

  // Add one edge to the model graph.
  function automatic void record_edge(node_t a, node_t b);
    if (a < MAX_NODES && b < MAX_NODES) begin
      if (node_deg[a] != DEG_MAX) node_deg[a] = node_deg[a] + 1'b1;
      if (node_deg[b] != DEG_MAX) node_deg[b] = node_deg[b] + 1'b1;
      adj_rows[a][b] = 1'b1;
      adj_rows[b][a] = 1'b1;
    end
  endfunction

  // Walk all triangles, queue the expected result and clear the graph.
  function automatic void search_min_triangle();
    tri_result_t r;
    int          best;
    int          s;
    logic        hit;
    hit  = 1'b0;
    best = int'(OUT_MAX);
    for (int i = 0; i < MAX_NODES; i++) begin
      for (int j = i + 1; j < MAX_NODES; j++) begin
        if (adj_rows[i][j]) begin
          for (int k = j + 1; k < MAX_NODES; k++) begin
            if (adj_rows[i][k] && adj_rows[j][k]) begin
              s = int'(node_deg[i]) + int'(node_deg[j]) + int'(node_deg[k]);
              s = (s >= TRI_OFFSET) ? s - TRI_OFFSET : 0;
              if (s > int'(OUT_MAX)) s = int'(OUT_MAX);
              hit = 1'b1;
              if (s < best) best = s;
            end
          end
        end
      end
    end
    r.found   = hit;
    r.min_deg = hit ? out_t'(best) : '0;
    pending_triangle_results = {pending_triangle_results, r};
    foreach (adj_rows[n]) begin
      adj_rows[n] = '0;
      node_deg[n] = '0;
    end
  endfunction

  // Offer one edge, wait for its transfer and update the model.
  // Valid is left high after the transfer; a drain lowers it, the next call only when it idles.
  task automatic send_edge(node_t a, node_t b, logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      edge_ch.valid <= 1'b0;
      @(posedge clk);
    end
    edge_ch.valid     <= 1'b1;
    edge_ch.node_a    <= a;
    edge_ch.node_b    <= b;
    edge_ch.last_edge <= last;
    @(posedge clk);
    while (!edge_ch.ready) @(posedge clk);
    record_edge(a, b);
    if (last) search_min_triangle();
  endtask

  // Hold the sender off until every expected result has been taken.
  task automatic drain_results();
    edge_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_triangle_results.size() != 0) @(posedge clk);
  endtask

  // Smallest triangles, at both ends of the node range.
  task automatic test_single_triangles();
    send_edge(6'd0, 6'd1, 1'b0);
    send_edge(6'd1, 6'd2, 1'b0);
    send_edge(6'd2, 6'd0, 1'b1);
    send_edge(6'd61, 6'd62, 1'b0);
    send_edge(6'd63, 6'd62, 1'b0);
    send_edge(6'd61, 6'd63, 1'b1);
  endtask

  // Graphs without a triangle: one plain edge, one self-loop.
  task automatic test_no_triangle();
    send_edge(6'd0, 6'd63, 1'b1);
    send_edge(6'd5, 6'd5, 1'b1);
  endtask

  // Duplicate edge, self-loop on a triangle node and alternating bit patterns.
  task automatic test_duplicates_and_loops();
    send_edge(6'd0, 6'd63, 1'b0);
    send_edge(6'd63, 6'd0, 1'b0);
    send_edge(6'd63, 6'd32, 1'b0);
    send_edge(6'd32, 6'd32, 1'b0);
    send_edge(6'd21, 6'd42, 1'b0);
    send_edge(6'd0, 6'd32, 1'b1);
  endtask

  // A four-clique next to a sparse triangle: the sparse one must win.
  task automatic test_min_selection();
    send_edge(6'd60, 6'd61, 1'b0);
    send_edge(6'd60, 6'd62, 1'b0);
    send_edge(6'd60, 6'd63, 1'b0);
    send_edge(6'd61, 6'd62, 1'b0);
    send_edge(6'd61, 6'd63, 1'b0);
    send_edge(6'd62, 6'd63, 1'b0);
    send_edge(6'd3, 6'd1, 1'b0);
    send_edge(6'd2, 6'd3, 1'b0);
    send_edge(6'd1, 6'd2, 1'b1);
  endtask

  // Random graphs over small node pools, with stray edges and self-loops.
  task automatic test_random_graphs(int item_target, int graph_floor);
    node_t pool [12];
    node_t a;
    node_t b;
    int    pool_n;
    int    n_edges;
    int    pick;
    int    items;
    int    graphs;
    items  = 0;
    graphs = 0;
    while (items < item_target || graphs < graph_floor) begin
      pool_n = $urandom_range(3, 12);
      foreach (pool[p]) pool[p] = node_t'($urandom_range(0, MAX_NODES - 1));
      n_edges = ($urandom_range(0, 19) == 0) ? $urandom_range(31, 90) : $urandom_range(1, 30);
      for (int e = 0; e < n_edges; e++) begin
        pick = $urandom_range(0, 99);
        a    = pool[$urandom_range(0, pool_n - 1)];
        b    = pool[$urandom_range(0, pool_n - 1)];
        if (pick < 8) begin
          b = node_t'($urandom_range(0, MAX_NODES - 1));
        end else if (pick < 11) begin
          b = a;
        end
        send_edge(a, b, e == n_edges - 1);
      end
      items  += n_edges;
      graphs += 1;
      if ($urandom_range(0, 3) == 0) drain_results();
    end
  endtask

  // Result receiver with random stalls.
  always @(posedge clk) begin
    if (rst) begin
      result_ch.ready <= 1'b0;
    end else begin
      result_ch.ready <= ($urandom_range(99) >= take_idle_pct);
    end
  end

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk) begin
    tri_result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_triangle_results.size() == 0) begin
        $error("unexpected result: found %0d, min_outside_degree %0d",
               result_ch.found, result_ch.min_outside_degree);
        error_count++;
      end else begin
        want = pending_triangle_results.pop_front();
        if (result_ch.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, result_ch.found);
          error_count++;
        end
        if (result_ch.min_outside_degree !== want.min_deg) begin
          $error("min_outside_degree: expected %0d, actual %0d",
                 want.min_deg, result_ch.min_outside_degree);
          error_count++;
        end
      end
    end
  end

  // Test sequence.
  initial begin
    edge_ch.valid     <= 1'b0;
    edge_ch.node_a    <= '0;
    edge_ch.node_b    <= '0;
    edge_ch.last_edge <= 1'b0;
    foreach (adj_rows[n]) begin
      adj_rows[n] = '0;
      node_deg[n] = '0;
    end
    send_idle_pct = 14;
    take_idle_pct = 87;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_single_triangles();
    test_no_triangle();
    test_duplicates_and_loops();
    test_min_selection();
    test_random_graphs(270, 15);
    drain_results();

    send_idle_pct = 87;
    take_idle_pct = 14;
    test_random_graphs(270, 15);
    drain_results();

    send_idle_pct = 0;
    take_idle_pct = 0;
    test_random_graphs(270, 15);

    // Let any stray result show up after the last expected one.
    drain_results();
    repeat (2500) @(posedge clk);
    if (error_count == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #200_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule

// File: filelist.f
rtl/mtf_pkg.sv
rtl/mtf_if.sv
rtl/mtf_store.sv
rtl/mtf_acc.sv
rtl/mtf_ctrl.sv
rtl/min_degree_triangle_finder.sv
tb/tb_min_degree_triangle_finder.sv
